// ----- rtl/pgf_pkg.sv -----
`timescale 1ns / 1ps

package pgf_pkg;

   typedef struct packed {
      logic [15:0]        attractor_id;
      logic [15:0]        body_id;
      logic signed [31:0] attractor_x;
      logic signed [31:0] attractor_y;
      logic signed [31:0] attractor_z;
      logic signed [31:0] body_x;
      logic signed [31:0] body_y;
      logic signed [31:0] body_z;
      logic [31:0]        attractor_mass;
      logic [31:0]        body_mass;
   } req_type;

   typedef struct packed {
      logic signed [47:0] force_x;
      logic signed [47:0] force_y;
      logic signed [47:0] force_z;
      logic               self_pair;
      logic               force_saturated;
   } rsp_type;

   // register indexes
   localparam logic CsrGrav = 1'b0;
   localparam logic CsrMinDist = 1'b1;

   localparam logic [31:0] GravReset = 32'd65536;
   localparam logic [31:0] MinDistReset = 32'd655;

   // deep section: one quotient bit of the force divide per stage; the square root
   // and the three direction divides share the same stages
   localparam int NumDeep = 96;
   localparam int SqrtSteps = 34;
   localparam int UnitStart = 34;
   localparam int UnitSteps = 31;

   // force magnitude clamp: anything above still saturates for a nonzero direction
   localparam logic [95:0] QMax = 96'd1 << 78;

   localparam logic [79:0] LimPos = (80'd1 << 47) - 80'd1;
   localparam logic [79:0] LimNeg = 80'd1 << 47;

   typedef struct packed {
      logic             self_pair;
      logic             zero;
      logic [2:0]       neg;
      logic [2:0][32:0] ad;
      logic [67:0]      s;
      logic [33:0]      root;
      logic [35:0]      srem;
      logic [57:0]      dv;
      logic [95:0]      p;
      logic [57:0]      rem;
      logic [95:0]      q;
      logic [2:0][33:0] urem;
      logic [2:0][30:0] uq;
   } dp_type;

   function automatic dp_type dp_step(input dp_type a, input int k);
      dp_type      r;
      logic [58:0] drem;
      logic [37:0] srem2;
      logic [37:0] trial;
      logic [33:0] usrc;
      logic        ubit;
      logic [34:0] urem2;
      r = a;
      // restoring divide, one quotient bit
      drem = {a.rem, a.p[95]};
      r.p = {a.p[94:0], 1'b0};
      if (drem >= {1'b0, a.dv}) begin
         r.rem = 58'(drem - {1'b0, a.dv});
         r.q = {a.q[94:0], 1'b1};
      end else begin
         r.rem = drem[57:0];
         r.q = {a.q[94:0], 1'b0};
      end
      // square root, two radicand bits per step
      srem2 = {a.srem, a.s[67:66]};
      trial = {2'b00, a.root, 2'b01};
      if (k < SqrtSteps) begin
         r.s = {a.s[65:0], 2'b00};
         if (srem2 >= trial) begin
            r.srem = 36'(srem2 - trial);
            r.root = {a.root[32:0], 1'b1};
         end else begin
            r.srem = srem2[35:0];
            r.root = {a.root[32:0], 1'b0};
         end
      end
      // direction divides by the length (root is final from UnitStart on)
      for (int i = 0; i < 3; i++) begin
         usrc = (k == UnitStart) ? 34'(a.ad[i] >> 1) : a.urem[i];
         ubit = (k == UnitStart) ? a.ad[i][0] : 1'b0;
         urem2 = {usrc, ubit};
         if (k >= UnitStart && k < UnitStart + UnitSteps) begin
            if (urem2 >= {1'b0, a.root}) begin
               r.urem[i] = 34'(urem2 - {1'b0, a.root});
               r.uq[i] = {a.uq[i][29:0], 1'b1};
            end else begin
               r.urem[i] = urem2[33:0];
               r.uq[i] = {a.uq[i][29:0], 1'b0};
            end
         end
      end
      return r;
   endfunction

endpackage

// ----- rtl/pairwise_gravity_force.sv -----
`timescale 1ns / 1ps

// channel   direction  handshake              payload
// req_      in         req_valid / req_ready  req_data (req_type)
// rsp_      out        rsp_valid / rsp_ready  rsp_data (rsp_type)
// csr_      in         csr_we                 csr_index, csr_wdata
//
// One request per cycle while the skid is empty; a response passes the front, deep and
// back stages and the output register, most of it the 96-stage restoring divider for the force magnitude.
// Reset clears all valid bits and loads the register defaults.
// A one-entry skid behind the output register takes the overflow when rsp_ready
// is low; while the skid holds a response req_ready is low and the pipe freezes.

module pairwise_gravity_force (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pgf_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pgf_pkg::rsp_type  rsp_data,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [31:0]       csr_wdata
);
   import pgf_pkg::*;

   logic [31:0] grav_ff, min_ff;
   logic        adv;

   // front stages
   logic             v0_ff, v1_ff, v2_ff;
   logic             self0_ff, self1_ff, self2_ff;
   logic [2:0]       neg0_ff, neg1_ff, neg2_ff;
   logic [2:0][32:0] ad0_ff, ad1_ff, ad2_ff;
   logic [2:0]       neg0_in;
   logic [2:0][32:0] ad0_in;
   logic [63:0]      gm0_ff;
   logic [31:0]      mb0_ff;
   logic [2:0][64:0] sq1_ff;
   logic [63:0]      plo1_ff, phi1_ff;
   logic [65:0]      ssum2_ff;
   logic [95:0]      prod2_ff;
   logic [2:0][31:0] apos, bpos;
   logic [2:0][32:0] diff;

   // deep stages
   dp_type dp_ff [0:NumDeep];
   dp_type dp_in [0:NumDeep-1];
   dp_type dp0_in;
   logic [NumDeep:0] dpv_ff;
   logic [49:0]      dsq, clamp;

   // back stages
   logic                  vm0_ff, vm1_ff, vm2_ff;
   logic                  selfm0_ff, selfm1_ff;
   logic                  zerom0_ff, zerom1_ff;
   logic [2:0]            negm0_ff, negm1_ff;
   logic [2:0][2:0][62:0] pp_ff, pp_in;
   logic [2:0][79:0]      mag_ff, mag_in;
   logic [78:0]           qc;
   logic [109:0]          msum;
   rsp_type               m2_ff, m2_in;
   logic [2:0][47:0]      fval;
   logic [79:0]           lim, mclip;
   logic                  sat;

   // output register and skid
   logic    out_v_ff, skid_v_ff;
   rsp_type out_ff, skid_ff;
   logic    take, push;

   always_ff @(posedge clock) begin
      if (reset) begin
         grav_ff <= GravReset;
         min_ff <= MinDistReset;
      end else if (csr_we) begin
         unique case (csr_index)
            CsrGrav:    grav_ff <= csr_wdata;
            CsrMinDist: min_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign adv = !skid_v_ff;
   assign req_ready = adv;

   // stage 0: differences, magnitudes, first mass product
   always_comb begin
      apos[0] = req_data.attractor_x;
      apos[1] = req_data.attractor_y;
      apos[2] = req_data.attractor_z;
      bpos[0] = req_data.body_x;
      bpos[1] = req_data.body_y;
      bpos[2] = req_data.body_z;
      for (int i = 0; i < 3; i++) begin
         diff[i] = {apos[i][31], apos[i]} - {bpos[i][31], bpos[i]};
         neg0_in[i] = diff[i][32];
         ad0_in[i] = diff[i][32] ? 33'(-diff[i]) : diff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= req_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         self0_ff <= req_data.attractor_id == req_data.body_id;
         neg0_ff <= neg0_in;
         ad0_ff <= ad0_in;
         gm0_ff <= grav_ff * req_data.attractor_mass;
         mb0_ff <= req_data.body_mass;
         // stage 1: squares, partial mass products
         self1_ff <= self0_ff;
         neg1_ff <= neg0_ff;
         ad1_ff <= ad0_ff;
         for (int i = 0; i < 3; i++) sq1_ff[i] <= ad0_ff[i] * ad0_ff[i];
         plo1_ff <= gm0_ff[31:0] * mb0_ff;
         phi1_ff <= gm0_ff[63:32] * mb0_ff;
         // stage 2: sums
         self2_ff <= self1_ff;
         neg2_ff <= neg1_ff;
         ad2_ff <= ad1_ff;
         ssum2_ff <= 66'(sq1_ff[0]) + 66'(sq1_ff[1]) + 66'(sq1_ff[2]);
         prod2_ff <= 96'(plo1_ff) + {phi1_ff, 32'd0};
      end
   end

   // stage 3: clamp the squared distance, load the deep section
   always_comb begin
      dsq = ssum2_ff[65:16];
      clamp = (min_ff == 32'd0) ? 50'd1 : 50'(min_ff);
      dp0_in = '0;
      dp0_in.self_pair = self2_ff;
      dp0_in.zero = ssum2_ff == 66'd0;
      dp0_in.neg = neg2_ff;
      dp0_in.ad = ad2_ff;
      dp0_in.s = {2'b00, ssum2_ff};
      dp0_in.dv = {(dsq < clamp) ? clamp : dsq, 8'd0};
      dp0_in.p = prod2_ff;
   end

   for (genvar k = 0; k < NumDeep; k++) begin : g_deep
      assign dp_in[k] = dp_step(dp_ff[k], k);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dpv_ff <= '0;
      end else if (adv) begin
         dpv_ff <= {dpv_ff[NumDeep-1:0], v2_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dp_ff[0] <= dp0_in;
         for (int k = 0; k < NumDeep; k++) dp_ff[k+1] <= dp_in[k];
      end
   end

   // back end: clamp magnitude, partial products, sum, saturate
   always_comb begin
      qc = (dp_ff[NumDeep].q > QMax) ? QMax[78:0] : dp_ff[NumDeep].q[78:0];
      for (int i = 0; i < 3; i++) begin
         pp_in[i][0] = qc[31:0] * dp_ff[NumDeep].uq[i];
         pp_in[i][1] = qc[63:32] * dp_ff[NumDeep].uq[i];
         pp_in[i][2] = 63'(qc[78:64]) * 63'(dp_ff[NumDeep].uq[i]);
      end
   end

   always_comb begin
      msum = '0;
      for (int i = 0; i < 3; i++) begin
         msum = 110'(pp_ff[i][0]) + {15'd0, pp_ff[i][1], 32'd0} + {pp_ff[i][2][45:0], 64'd0};
         mag_in[i] = msum[109:30];
      end
   end

   always_comb begin
      sat = 1'b0;
      lim = '0;
      mclip = '0;
      for (int i = 0; i < 3; i++) begin
         lim = negm1_ff[i] ? LimNeg : LimPos;
         mclip = mag_ff[i];
         if (mag_ff[i] > lim) begin
            mclip = lim;
            sat = 1'b1;
         end
         fval[i] = negm1_ff[i] ? 48'(-mclip[47:0]) : mclip[47:0];
      end
      m2_in.force_x = fval[0];
      m2_in.force_y = fval[1];
      m2_in.force_z = fval[2];
      m2_in.self_pair = selfm1_ff;
      m2_in.force_saturated = sat;
      if (selfm1_ff || zerom1_ff) begin
         m2_in.force_x = '0;
         m2_in.force_y = '0;
         m2_in.force_z = '0;
         m2_in.force_saturated = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vm0_ff <= 1'b0;
         vm1_ff <= 1'b0;
         vm2_ff <= 1'b0;
      end else if (adv) begin
         vm0_ff <= dpv_ff[NumDeep];
         vm1_ff <= vm0_ff;
         vm2_ff <= vm1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pp_ff <= pp_in;
         selfm0_ff <= dp_ff[NumDeep].self_pair;
         zerom0_ff <= dp_ff[NumDeep].zero;
         negm0_ff <= dp_ff[NumDeep].neg;
         mag_ff <= mag_in;
         selfm1_ff <= selfm0_ff;
         zerom1_ff <= zerom0_ff;
         negm1_ff <= negm0_ff;
         m2_ff <= m2_in;
      end
   end

   // output register with skid
   assign take = out_v_ff && rsp_ready;
   assign push = adv && vm2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (take) skid_v_ff <= 1'b0;
      end else if (push) begin
         if (out_v_ff && !take) skid_v_ff <= 1'b1;
         else out_v_ff <= 1'b1;
      end else if (take) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (take) out_ff <= skid_ff;
      end else if (push) begin
         if (out_v_ff && !take) skid_ff <= m2_ff;
         else out_ff <= m2_ff;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data = out_ff;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import pgf_pkg::*;

   localparam int Latency = 104;
   localparam int WatchLimit = 20000;
   localparam int NumRandom = 1950;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic csr_index = CsrGrav;
   logic [31:0] csr_wdata = '0;

   pairwise_gravity_force u_top (.*);

   always #5 clock = ~clock;

   req_type pending_reqs[$];
   rsp_type expected_forces[$];
   logic [31:0] grav_setting;
   logic [31:0] clamp_setting;
   int mismatches = 0;
   int idle_cycles = 0;
   int hold_cycles = 0;
   bit allow_hold = 1'b0;
   logic req_taken = 1'b0;

   // Newtonian pair force, exact wide integer arithmetic
   function automatic rsp_type gravity_force(req_type r);
      rsp_type f;
      logic signed [32:0] d[3];
      logic [32:0] ad[3];
      logic [67:0] ssum;
      logic [33:0] len;
      logic [35:0] cand;
      logic [67:0] dsq;
      logic [127:0] prod;
      logic [127:0] q;
      logic [127:0] u;
      logic [159:0] m;
      logic [159:0] mag;
      logic [47:0] lim;
      f = '0;
      if (r.attractor_id == r.body_id) begin
         f.self_pair = 1'b1;
         return f;
      end
      d[0] = 33'(r.attractor_x) - 33'(r.body_x);
      d[1] = 33'(r.attractor_y) - 33'(r.body_y);
      d[2] = 33'(r.attractor_z) - 33'(r.body_z);
      ssum = '0;
      for (int i = 0; i < 3; i++) begin
         ad[i] = d[i][32] ? 33'(-d[i]) : 33'(d[i]);
         ssum += 68'(ad[i]) * 68'(ad[i]);
      end
      if (ssum == 0) return f;
      len = '0;
      for (int b = 33; b >= 0; b--) begin
         cand = 36'(len | (34'd1 << b));
         if (72'(cand) * 72'(cand) <= 72'(ssum)) len = cand[33:0];
      end
      dsq = ssum >> 16;
      if (dsq < 68'(clamp_setting == 0 ? 32'd1 : clamp_setting))
         dsq = 68'(clamp_setting == 0 ? 32'd1 : clamp_setting);
      prod = 128'(grav_setting) * 128'(r.attractor_mass) * 128'(r.body_mass);
      q = prod / (128'(dsq) << 8);
      for (int i = 0; i < 3; i++) begin
         u = (128'(ad[i]) << 30) / 128'(len);
         m = 160'(q) * 160'(u);
         mag = m >> 30;
         lim = d[i][32] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
         if (mag > 160'(lim)) begin
            mag = 160'(lim);
            f.force_saturated = 1'b1;
         end
         if (i == 0) f.force_x = d[i][32] ? -mag[47:0] : mag[47:0];
         if (i == 1) f.force_y = d[i][32] ? -mag[47:0] : mag[47:0];
         if (i == 2) f.force_z = d[i][32] ? -mag[47:0] : mag[47:0];
      end
      return f;
   endfunction

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'($signed($urandom_range(0, 2000)) - 1000);
         3: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] rand_mass();
      case ($urandom_range(0, 4))
         0: return 32'hFFFF_FFFF;
         1: return $urandom_range(0, 65536 * 4);
         2: return 32'd0;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type rand_req();
      req_type r;
      r.attractor_id = 16'($urandom);
      r.body_id = ($urandom_range(0, 15) == 0) ? r.attractor_id : 16'($urandom);
      r.attractor_x = rand_coord();
      r.attractor_y = rand_coord();
      r.attractor_z = rand_coord();
      if ($urandom_range(0, 15) == 0) begin
         r.body_x = r.attractor_x;
         r.body_y = r.attractor_y;
         r.body_z = r.attractor_z;
      end else if ($urandom_range(0, 1)) begin
         // nearby body, so clamping and large forces appear
         r.body_x = r.attractor_x + 32'($signed($urandom_range(0, 200000)) - 100000);
         r.body_y = r.attractor_y + 32'($signed($urandom_range(0, 200000)) - 100000);
         r.body_z = r.attractor_z + 32'($signed($urandom_range(0, 200000)) - 100000);
      end else begin
         r.body_x = rand_coord();
         r.body_y = rand_coord();
         r.body_z = rand_coord();
      end
      r.attractor_mass = rand_mass();
      r.body_mass = rand_mass();
      return r;
   endfunction

   function automatic int rand_gap();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      if ($urandom_range(0, 1)) return 0;
      return $urandom_range(1, 3);
   endfunction

   task automatic write_reg(logic idx, logic [31:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CsrGrav) grav_setting = value;
      else clamp_setting = value;
   endtask

   task automatic drain();
      while (pending_reqs.size() != 0 || req_valid || expected_forces.size() != 0)
         @(negedge clock);
      repeat (Latency + 10) @(negedge clock);
   endtask

   // whether the request on the bus went in at the last rising edge
   always @(posedge clock) req_taken <= req_valid && req_ready;

   // driver
   int send_gap = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_taken) begin
         end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            req_data <= pending_reqs.pop_front();
            req_valid <= 1'b1;
            send_gap <= rand_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stalls, with one long hold-off
   int recv_gap = 0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (allow_hold && hold_cycles < 400) begin
         hold_cycles <= hold_cycles + 1;
         rsp_ready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap <= recv_gap - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) recv_gap <= rand_gap();
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) expected_forces.push_back(gravity_force(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_forces.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response %h", rsp_data);
            end else begin
               rsp_type e;
               e = expected_forces.pop_front();
               if (e !== rsp_data) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp %h %h %h sp%b sat%b got %h %h %h sp%b sat%b",
                        e.force_x, e.force_y, e.force_z, e.self_pair, e.force_saturated,
                        rsp_data.force_x, rsp_data.force_y, rsp_data.force_z,
                        rsp_data.self_pair, rsp_data.force_saturated);
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WatchLimit) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      req_type r;
      logic [31:0] gs[5];
      logic [31:0] cs[5];
      grav_setting = GravReset;
      clamp_setting = MinDistReset;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed requests at reset settings
      r = '0;
      r.attractor_id = 16'd1;
      r.body_id = 16'd1;
      r.attractor_x = 32'h0001_0000;
      r.attractor_mass = 32'h0001_0000;
      r.body_mass = 32'h0001_0000;
      pending_reqs.push_back(r);          // equal ids
      r.body_id = 16'd2;
      pending_reqs.push_back(r);          // unit distance on x
      r.attractor_x = -32'sd65536;
      r.attractor_y = 32'h0000_0100;
      pending_reqs.push_back(r);
      r.attractor_x = 32'd0;
      r.attractor_y = 32'd0;
      pending_reqs.push_back(r);          // coincident
      r.attractor_x = 32'd1;
      r.attractor_z = -32'sd1;
      r.attractor_mass = 32'hFFFF_FFFF;
      r.body_mass = 32'hFFFF_FFFF;
      pending_reqs.push_back(r);          // clamped distance, saturates
      r.attractor_x = 32'h7FFF_FFFF;
      r.attractor_y = 32'h7FFF_FFFF;
      r.attractor_z = 32'h7FFF_FFFF;
      r.body_x = 32'h8000_0000;
      r.body_y = 32'h8000_0000;
      r.body_z = 32'h8000_0000;
      r.attractor_id = 16'hFFFF;
      r.body_id = 16'h0000;
      pending_reqs.push_back(r);          // widest separation
      r.attractor_x = 32'h8000_0000;
      r.attractor_y = 32'h8000_0000;
      r.attractor_z = 32'h8000_0000;
      r.body_x = 32'h7FFF_FFFF;
      r.body_y = 32'h7FFF_FFFF;
      r.body_z = 32'h7FFF_FFFF;
      pending_reqs.push_back(r);
      r.attractor_mass = 32'd0;
      pending_reqs.push_back(r);
      for (int i = 0; i < 12; i++) pending_reqs.push_back(rand_req());
      drain();

      gs = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'h0001_0000, 32'h0000_0400};
      cs = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'h0100_0000, MinDistReset};
      for (int ph = 0; ph < 5; ph++) begin
         write_reg(CsrGrav, gs[ph]);
         write_reg(CsrMinDist, cs[ph]);
         if (ph == 3) allow_hold = 1'b1;
         for (int i = 0; i < NumRandom / 5; i++) pending_reqs.push_back(rand_req());
         drain();
      end
      // a final pass with random register values
      write_reg(CsrGrav, $urandom);
      write_reg(CsrMinDist, $urandom);
      for (int i = 0; i < 50; i++) pending_reqs.push_back(rand_req());
      drain();

      if (mismatches == 0 && expected_forces.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
